/* design/assert_macros.svh */
// Assertion macros shared by the mixer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/svm_pkg.sv */
// Shared constants, function codes and control/status types of the voice mixer.
`default_nettype none

package svm_pkg;

  localparam int VOICES_DEF       = 16;
  localparam int SAMPLE_DEPTH_DEF = 65536;

  localparam int FUNC_W     = 3;
  localparam int ADDR_W     = 16;
  localparam int POS_W      = 17;
  localparam int SOUND_W    = 6;
  localparam int VSEL_W     = 4;
  localparam int SAMPLE_W   = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  localparam logic [FUNC_W-1:0] FN_LOAD       = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PLAY       = 3'd1;
  localparam logic [FUNC_W-1:0] FN_STOP_SOUND = 3'd2;
  localparam logic [FUNC_W-1:0] FN_STOP_VOICE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_STOP_ALL   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_MIX        = 3'd5;

  typedef struct packed {
    logic capture;   // latch the input beat
    logic exec;      // perform load or stop action
    logic play_wr;   // claim a voice for play
    logic mix_step;  // process the addressed voice of a mix
    logic emit;      // load the result register
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] in_func;    // func of the beat on the input
    logic              cur_active; // addressed voice is playing
    logic              out_free;   // result register can take a beat
  } status_t;

endpackage

`default_nettype wire

/* design/svm_ctrl.sv */
// Sequencer of the voice mixer: item dispatch, voice scan and result hand-off.
`default_nettype none

`include "assert_macros.svh"

module svm_ctrl #(
  parameter int VOICES = svm_pkg::VOICES_DEF,
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  svm_pkg::status_t     status,
  output svm_pkg::cmd_t        cmd,
  output logic [VW-1:0]        voice_idx
);
  import svm_pkg::*;

  localparam logic [VW-1:0] LAST_IDX = VW'(VOICES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_MIX,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t        state_r, state_nxt;
  logic [VW-1:0] idx_r, idx_nxt;
  logic          in_tready_r, in_tready_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.capture  = (state_r == ST_IDLE) && in_tvalid && in_tready_r;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.play_wr  = (state_r == ST_SCAN) && (!status.cur_active || idx_r == LAST_IDX);
    cmd.mix_step = (state_r == ST_MIX);
    cmd.emit     = (state_r == ST_RESULT) && status.out_free;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (in_tvalid && in_tready_r) begin
          case (status.in_func)
            FN_PLAY: state_nxt = ST_SCAN;
            FN_MIX:  state_nxt = ST_MIX;
            default: state_nxt = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: state_nxt = ST_RESULT;
      ST_SCAN: begin
        if (cmd.play_wr) state_nxt = ST_RESULT;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_MIX: begin
        if (idx_r == LAST_IDX) state_nxt = ST_DRAIN;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_DRAIN: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_tready_nxt = (state_nxt == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;
  assign voice_idx = idx_r;

  `SVM_ASSERT_NXT(a_mix_to_drain, state_r == ST_MIX && idx_r == LAST_IDX, state_r == ST_DRAIN, "mix loop did not end after last voice")
  `SVM_ASSERT_NXT(a_emit_to_idle, cmd.emit, state_r == ST_IDLE && in_tready, "not ready after result hand-off")

endmodule

`default_nettype wire

/* design/svm_dp.sv */
// Datapath of the voice mixer: voice table, sample memory, accumulators, result register.
`default_nettype none

`include "assert_macros.svh"

module svm_dp #(
  parameter int VOICES       = svm_pkg::VOICES_DEF,
  parameter int SAMPLE_DEPTH = svm_pkg::SAMPLE_DEPTH_DEF,
  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic        [svm_pkg::FUNC_W-1:0]   in_func,
  input  wire logic        [svm_pkg::ADDR_W-1:0]   in_addr,
  input  wire logic        [svm_pkg::POS_W-1:0]    in_end_addr,
  input  wire logic        [svm_pkg::SOUND_W-1:0]  in_sound_id,
  input  wire logic        [svm_pkg::VSEL_W-1:0]   in_voice,
  input  wire logic signed [svm_pkg::SAMPLE_W-1:0] in_left_value,
  input  wire logic signed [svm_pkg::SAMPLE_W-1:0] in_right_value,
  input  svm_pkg::cmd_t                            cmd,
  input  wire logic        [VW-1:0]                voice_idx,
  output svm_pkg::status_t                         status,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic             [svm_pkg::VSEL_W-1:0]   out_voice,
  output logic signed      [svm_pkg::SAMPLE_W-1:0] out_left,
  output logic signed      [svm_pkg::SAMPLE_W-1:0] out_right
);
  import svm_pkg::*;

  localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

  // latched item
  logic [FUNC_W-1:0]          func_r;
  logic [ADDR_W-1:0]          addr_r;
  logic [POS_W-1:0]           end_addr_r;
  logic [SOUND_W-1:0]         sound_r;
  logic [VSEL_W-1:0]          vsel_r;
  logic signed [SAMPLE_W-1:0] acc_l_r, acc_rt_r;

  // voice table
  logic                active_r [VOICES];
  logic [POS_W-1:0]    pos_r    [VOICES];
  logic [POS_W-1:0]    vend_r   [VOICES];
  logic [SOUND_W-1:0]  snd_r    [VOICES];
  logic [VW-1:0]       play_voice_r;

  // sample memory
  logic [2*SAMPLE_W-1:0] mem [SAMPLE_DEPTH];
  logic [2*SAMPLE_W-1:0] rd_r;
  logic                  add_v_r, add_v_nxt;

  logic              out_tvalid_r;
  logic [VSEL_W-1:0] out_voice_r;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;

  logic             cur_active;
  logic [POS_W-1:0] cur_pos, cur_end;
  logic             pos_ok, addr_ok, at_end;
  logic [VW-1:0]    play_tgt;

  function automatic logic signed [SAMPLE_W-1:0] sat_add(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b
  );
    logic signed [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1])
      sat_add = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    else
      sat_add = s[SAMPLE_W-1:0];
  endfunction

  assign cur_active = active_r[voice_idx];
  assign cur_pos    = pos_r[voice_idx];
  assign cur_end    = vend_r[voice_idx];
  assign at_end     = (cur_pos == cur_end);
  assign pos_ok     = 32'(cur_pos) < SAMPLE_DEPTH;
  assign addr_ok    = 32'(addr_r) < SAMPLE_DEPTH;
  // scan stops on the first idle voice, or falls back to voice 0
  assign play_tgt   = cur_active ? '0 : voice_idx;
  assign add_v_nxt  = cmd.mix_step && cur_active && !at_end && pos_ok;

  assign status.in_func    = in_func;
  assign status.cur_active = cur_active;
  assign status.out_free   = !out_tvalid_r || out_tready;

  // item latch and mix accumulators
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      addr_r     <= in_addr;
      end_addr_r <= in_end_addr;
      sound_r    <= in_sound_id;
      vsel_r     <= in_voice;
      acc_l_r    <= in_left_value;
      acc_rt_r   <= in_right_value;
    end else if (add_v_r) begin
      acc_l_r  <= sat_add(acc_l_r, rd_r[SAMPLE_W-1:0]);
      acc_rt_r <= sat_add(acc_rt_r, rd_r[2*SAMPLE_W-1:SAMPLE_W]);
    end
    if (cmd.play_wr) play_voice_r <= play_tgt;
  end

  // voice table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        active_r[i] <= 1'b0;
        pos_r[i]    <= '0;
        vend_r[i]   <= '0;
        snd_r[i]    <= '0;
      end
    end else begin
      if (cmd.exec) begin
        case (func_r)
          FN_STOP_SOUND: begin
            for (int i = 0; i < VOICES; i++)
              if (snd_r[i] == sound_r) active_r[i] <= 1'b0;
          end
          FN_STOP_VOICE: begin
            if (32'(vsel_r) < VOICES) active_r[VW'(vsel_r)] <= 1'b0;
          end
          FN_STOP_ALL: begin
            for (int i = 0; i < VOICES; i++) begin
              active_r[i] <= 1'b0;
              pos_r[i]    <= '0;
              vend_r[i]   <= '0;
              snd_r[i]    <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.play_wr) begin
        active_r[play_tgt] <= 1'b1;
        pos_r[play_tgt]    <= POS_W'(addr_r);
        vend_r[play_tgt]   <= end_addr_r;
        snd_r[play_tgt]    <= sound_r;
      end
      if (cmd.mix_step && cur_active) begin
        if (at_end) active_r[voice_idx] <= 1'b0;
        else pos_r[voice_idx] <= cur_pos + 1'b1;
      end
    end
  end

  // sample memory: one write port for loads, one registered read for the mix
  always_ff @(posedge clk) begin
    if (cmd.exec && func_r == FN_LOAD && addr_ok)
      mem[AW'(addr_r)] <= {acc_rt_r, acc_l_r};
    rd_r <= mem[AW'(cur_pos)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) add_v_r <= 1'b0;
    else add_v_r <= add_v_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (cmd.emit) out_tvalid_r <= 1'b1;
    else if (out_tready) out_tvalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_voice_r <= (func_r == FN_PLAY) ? VSEL_W'(play_voice_r) : '0;
      out_left_r  <= (func_r == FN_MIX) ? acc_l_r : '0;
      out_right_r <= (func_r == FN_MIX) ? acc_rt_r : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_voice  = out_voice_r;
  assign out_left   = out_left_r;
  assign out_right  = out_right_r;

  `SVM_ASSERT_IMP(a_emit_when_free, cmd.emit, !out_tvalid_r || out_tready, "result overwritten before hand-off")
  `SVM_ASSERT_NXT(a_end_goes_idle, cmd.mix_step && cur_active && at_end, !active_r[$past(voice_idx)], "voice at end stayed active")

endmodule

`default_nettype wire

/* design/sample_voice_mixer_core.sv */
// Top level of the stereo sample playback voice mixer.
`default_nettype none

// Stereo 16-bit sample playback mixer with VOICES voices and a sample memory of
// SAMPLE_DEPTH stereo frames (one 32-bit word each, right sample in the upper half).
// Every input beat gives exactly one result beat. in_tuser carries the function:
// load a frame, play, stop by sound id, stop one voice, stop all, or mix one frame.
// Per item: load and the stop functions act in an execute state and then offer
// their result; play scans the voice table one voice a cycle for the first idle
// one and offers its result when the scan stops; mix visits every voice in order,
// one sample memory read per voice, adds the last read in a drain state and then
// offers its result. The next beat can be taken once the result is loaded into
// the output register. The sample accumulators saturate to 16 bits after every
// added sample. The next beat is accepted while a finished result still waits in
// the output register; a result held there only delays the completion of the
// following item. in_tready is registered and reset clears it, so it rises only
// after reset is released. The sample memory has no reset and no clearing pass:
// a voice must only ever read frames that were loaded. After reset all voices are
// idle with position, end and sound id zero.

module sample_voice_mixer_core #(
  parameter int VOICES       = svm_pkg::VOICES_DEF,
  parameter int SAMPLE_DEPTH = svm_pkg::SAMPLE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // in_tdata, from bit 0 up: addr[16], end_addr[17], sound_id[6], voice[4],
  // left_value[16], right_value[16], zero pad[5]
  input  wire logic [svm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: func[3]
  input  wire logic [svm_pkg::FUNC_W-1:0]        in_tuser,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // out_tdata, from bit 0 up: voice_out[4], left_out[16], right_out[16], zero pad[4]
  output logic [svm_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready
);
  import svm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [VW-1:0] voice_idx;

  logic [VSEL_W-1:0]          out_voice;
  logic signed [SAMPLE_W-1:0] out_left, out_right;

  // Sequencer: dispatch on func, run the voice loops, hand off the result.
  svm_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .voice_idx (voice_idx)
  );

  // Datapath: unpack the input beat straight into the item latch.
  svm_dp #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_tuser),
    .in_addr        (in_tdata[15:0]),
    .in_end_addr    (in_tdata[32:16]),
    .in_sound_id    (in_tdata[38:33]),
    .in_voice       (in_tdata[42:39]),
    .in_left_value  (in_tdata[58:43]),
    .in_right_value (in_tdata[74:59]),
    .cmd            (cmd),
    .voice_idx      (voice_idx),
    .status         (status),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_voice      (out_voice),
    .out_left       (out_left),
    .out_right      (out_right)
  );

  // Pack the result beat; pad bits stay zero.
  assign out_tdata = {4'b0000, out_right, out_left, out_voice};

endmodule

`default_nettype wire
